### src/bop_pkg.sv
package bop_pkg;

    localparam int ADDR_W  = 64;
    localparam int OCC_W   = 7;

    // Command queue between the front and the back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    localparam logic KIND_ACCESS = 1'b0;
    localparam logic KIND_FILL   = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] line_address;
        logic [ADDR_W-1:0] evicted_address;
        logic [OCC_W-1:0]  mshr_occupancy;
    } bop_in_t;

    typedef struct packed {
        logic [ADDR_W-1:0] prefetch_address;
        logic              llc_only;
    } bop_out_t;

    typedef struct packed {
        logic              is_fill;
        logic              llc_only;
        logic [ADDR_W-1:0] line_address;
        logic [ADDR_W-1:0] evicted_address;
    } bop_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CMP  = 3'b010,
        ST_ACT  = 3'b100
    } bop_state_t;

endpackage

### src/best_offset_prefetcher_top.sv
// Best-offset L2 prefetcher.
// Input channel (in_valid / in_stall / in_data): one beat per L2 demand access
// (kind 0) or per cache fill (kind 1, with the evicted line's address).
// Output channel (out_valid / out_stall / out_data): one prefetch beat per
// access, none per fill. Beats leave in the order their accesses arrived.
// Config: cfg_write with cfg_data loads the LLC occupancy limit (reset 13);
// write it idle.
// Path: with the back end idle, an accepted access is written into the
// command queue, popped, and its prefetch registered in the output register.
// The back sequencer takes no new item until its steps are done (history tag
// compare, first-match pick, score read-modify-write through the score
// memory). A 2-beat command queue decouples the sides.
// Reset: history tags clear to zero, all history lines invalid, best offset
// and best score one. The score memory is covered by per-entry valid bits, so
// there is no clearing pass; the block takes beats right after reset.
// Output stall: the output register holds its beat; the back end waits before
// the next access, fills ahead of it in the queue keep going, and once the
// queue is full in_stall rises.
module best_offset_prefetcher_top #(
    parameter int HISTORY_DEPTH = 64,
    parameter int OFFSET_COUNT  = 128,
    parameter int MAX_SCORE     = 127,
    parameter int LINE_BITS     = 6,
    parameter int TAG_BITS      = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  bop_pkg::bop_in_t          in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output bop_pkg::bop_out_t         out_data,
    input  logic                      cfg_write,
    input  logic [bop_pkg::OCC_W-1:0] cfg_data
);

    logic [bop_pkg::OCC_W-1:0] occ_limit_reg;
    logic                      cmd_valid;
    logic                      cmd_pop;
    bop_pkg::bop_cmd_t         cmd;

    // Hold the occupancy limit; load it on a config beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_limit_reg <= bop_pkg::OCC_W'(13);
        end
        else if (cfg_write)
        begin
            occ_limit_reg <= cfg_data;
        end
    end

    // Front: accept beats, classify, queue them
    bop_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .occ_limit  (occ_limit_reg),
        .cmd_valid  (cmd_valid),
        .cmd_pop    (cmd_pop),
        .cmd        (cmd)
    );

    // Back: emit prefetches, keep history, train offsets
    bop_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .OFFSET_COUNT  (OFFSET_COUNT),
        .MAX_SCORE     (MAX_SCORE),
        .LINE_BITS     (LINE_BITS),
        .TAG_BITS      (TAG_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // A full queue always has a command waiting
    a_stall_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> cmd_valid)
        else $error("input stalled with an empty command queue");

    // The back end pops only what is there
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command popped from an empty queue");

    // A new output beat only follows the pop of an access
    a_out_from_access: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd_pop && !cmd.is_fill))
        else $error("output beat without an access command");

endmodule

### src/bop_front.sv
module bop_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  bop_pkg::bop_in_t          in_data,
    input  logic [bop_pkg::OCC_W-1:0] occ_limit,
    output logic                      cmd_valid,
    input  logic                      cmd_pop,
    output bop_pkg::bop_cmd_t         cmd
);

    bop_pkg::bop_cmd_t                q_reg [bop_pkg::Q_DEPTH];
    logic [bop_pkg::Q_PTR_W-1:0]      wr_ptr_reg;
    logic [bop_pkg::Q_PTR_W-1:0]      rd_ptr_reg;
    logic [bop_pkg::Q_CNT_W-1:0]      count_reg;
    logic [bop_pkg::Q_CNT_W-1:0]      count_next;
    logic                             push;
    bop_pkg::bop_cmd_t                new_cmd;

    assign in_stall  = (count_reg == bop_pkg::Q_CNT_W'(bop_pkg::Q_DEPTH));
    assign push      = in_valid && !in_stall;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];

    // Classify the beat and settle the fill target now
    always_comb
    begin
        new_cmd.is_fill         = (in_data.kind == bop_pkg::KIND_FILL);
        new_cmd.llc_only        = (in_data.mshr_occupancy >= occ_limit);
        new_cmd.line_address    = in_data.line_address;
        new_cmd.evicted_address = in_data.evicted_address;
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !(cmd_pop && cmd_valid))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && cmd_pop && cmd_valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (cmd_pop && cmd_valid)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

### src/bop_back.sv
module bop_back #(
    parameter int HISTORY_DEPTH = 64,
    parameter int OFFSET_COUNT  = 128,
    parameter int MAX_SCORE     = 127,
    parameter int LINE_BITS     = 6,
    parameter int TAG_BITS      = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_pop,
    input  bop_pkg::bop_cmd_t cmd,
    output logic              out_valid,
    input  logic              out_stall,
    output bop_pkg::bop_out_t out_data
);

    localparam int HP_W  = $clog2(HISTORY_DEPTH);
    localparam int TP_W  = $clog2(OFFSET_COUNT);
    localparam int OFF_W = $clog2(OFFSET_COUNT + 1);
    localparam int SC_W  = $clog2(MAX_SCORE + 1);

    bop_pkg::bop_state_t          state_reg;
    bop_pkg::bop_state_t          state_next;

    logic [TAG_BITS-1:0]          hist_tag_reg [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0]     hist_valid_reg;
    logic [HISTORY_DEPTH-1:0]     hist_valid_next;
    logic [HP_W-1:0]              ins_ptr_reg;
    logic [TP_W-1:0]              train_ptr_reg;
    logic [OFF_W-1:0]             best_off_reg;
    logic [OFF_W-1:0]             best_off_next;
    logic [SC_W-1:0]              best_score_reg;
    logic [SC_W-1:0]              best_score_next;

    logic [SC_W-1:0]              score_mem [OFFSET_COUNT];
    logic [OFFSET_COUNT-1:0]      score_vld_reg;
    logic [SC_W-1:0]              score_rd_reg;
    logic                         score_rd_vld_reg;
    logic [SC_W-1:0]              score_cur;
    logic [SC_W-1:0]              score_new;

    logic                         op_fill_reg;
    logic [TAG_BITS-1:0]          key_a_reg;
    logic [TAG_BITS-1:0]          key_b_reg;
    logic [HISTORY_DEPTH-1:0]     match_a_reg;
    logic [HISTORY_DEPTH-1:0]     match_b_reg;
    logic [HISTORY_DEPTH-1:0]     match_a_next;
    logic [HISTORY_DEPTH-1:0]     match_b_next;
    logic [HISTORY_DEPTH-1:0]     first_a;
    logic [HISTORY_DEPTH-1:0]     first_b;

    logic                         out_valid_reg;
    bop_pkg::bop_out_t            out_data_reg;

    logic                         out_free;
    logic                         launch_acc;
    logic                         do_train;
    logic                         hit;
    logic [OFF_W-1:0]             cur_off;
    logic [TAG_BITS-1:0]          acc_tag;
    logic [TAG_BITS-1:0]          fill_tag;
    logic [TAG_BITS-1:0]          ev_tag;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    assign acc_tag  = cmd.line_address[LINE_BITS +: TAG_BITS];
    assign fill_tag = cmd.line_address[LINE_BITS +: TAG_BITS];
    assign ev_tag   = cmd.evicted_address[LINE_BITS +: TAG_BITS];
    assign cur_off  = OFF_W'(train_ptr_reg) + OFF_W'(1);

    // Take a command only from idle; an access also needs room at the output
    assign cmd_pop    = (state_reg == bop_pkg::ST_IDLE) && cmd_valid
                        && (cmd.is_fill || out_free);
    assign launch_acc = cmd_pop && !cmd.is_fill;
    assign do_train   = (state_reg == bop_pkg::ST_ACT) && !op_fill_reg;

    always_comb
    begin
        for (int i = 0; i < HISTORY_DEPTH; i++)
        begin
            match_a_next[i] = (hist_tag_reg[i] == key_a_reg);
            match_b_next[i] = (hist_tag_reg[i] == key_b_reg);
        end
    end

    // Lowest matching slot wins
    assign first_a = match_a_reg & (~match_a_reg + HISTORY_DEPTH'(1));
    assign first_b = match_b_reg & (~match_b_reg + HISTORY_DEPTH'(1));
    assign hit     = |(first_a & hist_valid_reg);

    // Entries never written read as their reset score
    always_comb
    begin
        if (score_rd_vld_reg)
        begin
            score_cur = score_rd_reg;
        end
        else if (train_ptr_reg == TP_W'(0))
        begin
            score_cur = SC_W'(1);
        end
        else
        begin
            score_cur = '0;
        end
    end

    always_comb
    begin
        best_off_next   = best_off_reg;
        best_score_next = best_score_reg;
        if (hit)
        begin
            score_new = (score_cur < SC_W'(MAX_SCORE)) ? score_cur + 1'b1 : score_cur;
            if (score_new > best_score_reg)
            begin
                best_off_next   = cur_off;
                best_score_next = score_new;
            end
        end
        else
        begin
            score_new = (score_cur != '0) ? score_cur - 1'b1 : score_cur;
            if ((cur_off == best_off_reg) && (best_score_reg != '0))
            begin
                best_score_next = best_score_reg - 1'b1;
            end
        end
    end

    always_comb
    begin
        hist_valid_next = hist_valid_reg;
        if (launch_acc)
        begin
            hist_valid_next[ins_ptr_reg] = 1'b0;
        end
        else if ((state_reg == bop_pkg::ST_ACT) && op_fill_reg)
        begin
            // Set first, then clear: equal tags leave the slot invalid
            hist_valid_next = (hist_valid_reg | first_a) & ~first_b;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bop_pkg::ST_IDLE:
            begin
                if (cmd_pop)
                begin
                    state_next = bop_pkg::ST_CMP;
                end
            end
            bop_pkg::ST_CMP:  state_next = bop_pkg::ST_ACT;
            bop_pkg::ST_ACT:  state_next = bop_pkg::ST_IDLE;
            default:          state_next = bop_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bop_pkg::ST_IDLE;
            hist_valid_reg <= '0;
            ins_ptr_reg    <= '0;
            train_ptr_reg  <= '0;
            best_off_reg   <= OFF_W'(1);
            best_score_reg <= SC_W'(1);
            score_vld_reg  <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                hist_tag_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            hist_valid_reg <= hist_valid_next;
            if (launch_acc)
            begin
                hist_tag_reg[ins_ptr_reg] <= acc_tag;
                ins_ptr_reg <= (ins_ptr_reg == HP_W'(HISTORY_DEPTH - 1))
                               ? '0 : ins_ptr_reg + 1'b1;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (do_train)
            begin
                best_off_reg   <= best_off_next;
                best_score_reg <= best_score_next;
                score_vld_reg[train_ptr_reg] <= 1'b1;
                train_ptr_reg  <= (train_ptr_reg == TP_W'(OFFSET_COUNT - 1))
                                  ? '0 : train_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            op_fill_reg <= cmd.is_fill;
            key_a_reg   <= cmd.is_fill ? fill_tag : acc_tag - TAG_BITS'(cur_off);
            key_b_reg   <= ev_tag;
        end
        if (state_reg == bop_pkg::ST_CMP)
        begin
            match_a_reg <= match_a_next;
            match_b_reg <= match_b_next;
        end
        if (launch_acc)
        begin
            out_data_reg.prefetch_address <= cmd.line_address
                + (bop_pkg::ADDR_W'(best_off_reg) << LINE_BITS);
            out_data_reg.llc_only <= cmd.llc_only;
            score_rd_reg     <= score_mem[train_ptr_reg];
            score_rd_vld_reg <= score_vld_reg[train_ptr_reg];
        end
        if (do_train)
        begin
            score_mem[train_ptr_reg] <= score_new;
        end
    end

endmodule
